### src/skdf_pkg.sv
`default_nettype none
package skdf_pkg;

	localparam int FRACTION_BITS_DEF = 16;
	localparam int DISTANCE_BITS_DEF = 9;

	localparam int NOISE_W   = 24;
	localparam int THRESH_W  = 9;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = NOISE_W;

	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

	localparam cfg_idx_t REG_PROCESS_NOISE     = cfg_idx_t'(0);
	localparam cfg_idx_t REG_MEASUREMENT_NOISE = cfg_idx_t'(1);
	localparam cfg_idx_t REG_NEAR_THRESHOLD    = cfg_idx_t'(2);

	localparam logic [THRESH_W-1:0] NEAR_THRESHOLD_RST = THRESH_W'(20);

endpackage
`default_nettype wire

### src/skdf_if.sv
`default_nettype none

interface skdf_cfg_if;
	import skdf_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;
	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

interface skdf_in_if #(parameter int DIST_W = 9);
	logic              valid;
	logic              ready;
	logic [DIST_W-1:0] reading_cm;
	modport source (output valid, output reading_cm, input ready);
	modport sink   (input valid, input reading_cm, output ready);
endinterface

interface skdf_out_if #(parameter int VAL_W = 25);
	logic             valid;
	logic             ready;
	logic [VAL_W-1:0] filtered_distance;
	logic             obstacle_near;
	modport source (output valid, output filtered_distance, output obstacle_near, input ready);
	modport sink   (input valid, input filtered_distance, input obstacle_near, output ready);
endinterface

`default_nettype wire

### src/scalar_kalman_distance_filter_top.sv
// An accepted reading passes through the restoring divider, one bit of gain per cycle,
// then through the two serial-parallel multipliers, one gain bit per cycle, then a finish
// state that waits until the previous result has been taken (dout.ready).
// A new reading is accepted only in idle, after the previous one has finished.
// Reset (arst_n low, asynchronous): estimate 0, covariance 1.0, noise and threshold registers
// to their defaults, no result pending.
`default_nettype none
module scalar_kalman_distance_filter_top #(
	parameter int FRACTION_BITS = skdf_pkg::FRACTION_BITS_DEF,
	parameter int DISTANCE_BITS = skdf_pkg::DISTANCE_BITS_DEF
) (
	input  wire logic   clk,
	input  wire logic   arst_n,
	skdf_cfg_if.sink    cfg,
	skdf_in_if.sink     din,
	skdf_out_if.source  dout
);
	import skdf_pkg::*;

	localparam int F      = FRACTION_BITS;
	localparam int VAL_W  = DISTANCE_BITS + FRACTION_BITS;
	localparam int S_W    = ((VAL_W > NOISE_W) ? VAL_W : NOISE_W) + 1;
	localparam int R_W    = S_W + 1;
	localparam int K_W    = F + 1;
	localparam int Y_W    = VAL_W + 1;
	localparam int ACCY_W = VAL_W + 2;
	localparam int ACCP_W = VAL_W + 1;
	localparam int XN_W   = VAL_W + 3;
	localparam int PN_W   = ((ACCP_W > NOISE_W) ? ACCP_W : NOISE_W) + 1;
	localparam int CMP_W  = (VAL_W > THRESH_W + F) ? VAL_W : THRESH_W + F;
	localparam int CNT_W  = $clog2(F + 1);

	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(F);
	localparam logic [VAL_W-1:0] VAL_MAX  = {VAL_W{1'b1}};
	localparam logic [VAL_W-1:0] P_RST    = VAL_W'(1) << F;
	localparam logic [K_W-1:0]   K_ONE    = K_W'(1) << F;
	localparam logic [NOISE_W-1:0] Q_RST  = NOISE_W'((2 ** F) / 100);
	localparam logic [NOISE_W-1:0] R_RST  = NOISE_W'(2 ** F);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_DIV  = 2'd1;
	localparam logic [1:0] ST_MUL  = 2'd2;
	localparam logic [1:0] ST_FIN  = 2'd3;

	logic [1:0]          state_q;
	logic [CNT_W-1:0]    cnt_q;
	logic [NOISE_W-1:0]  q_noise_q;
	logic [NOISE_W-1:0]  r_noise_q;
	logic [THRESH_W-1:0] thresh_q;
	logic [VAL_W-1:0]    x_q;
	logic [VAL_W-1:0]    p_q;
	logic [S_W-1:0]      s_q;
	logic [R_W-1:0]      rem_q;
	logic [K_W-1:0]      k_q;
	logic [K_W-1:0]      a_q;
	logic signed [Y_W-1:0]    y_q;
	logic signed [ACCY_W-1:0] accy_q;
	logic [ACCP_W-1:0]   accp_q;
	logic                out_valid_q;
	logic [VAL_W-1:0]    out_dist_q;
	logic                out_near_q;

	logic [R_W-1:0]      trial;
	logic                qbit;
	logic [R_W-1:0]      rem_next;
	logic [K_W-1:0]      k_next;
	logic signed [ACCY_W-1:0] sumy;
	logic [ACCP_W-1:0]   sump;
	logic signed [XN_W-1:0]   xn_raw;
	logic [VAL_W-1:0]    xn;
	logic [PN_W-1:0]     pn_raw;
	logic [VAL_W-1:0]    pn;
	logic                near;
	logic                fin_go;

	assign cfg.ready = 1'b1;
	assign din.ready = (state_q == ST_IDLE);
	assign dout.valid = out_valid_q;
	assign dout.filtered_distance = out_dist_q;
	assign dout.obstacle_near = out_near_q;

	// restoring divide step: first step compares unshifted remainder
	always_comb begin
		trial    = (cnt_q == '0) ? rem_q : {rem_q[R_W-2:0], 1'b0};
		qbit     = (trial >= R_W'(s_q));
		rem_next = qbit ? (trial - R_W'(s_q)) : trial;
		k_next   = (s_q == '0) ? '0 : {k_q[K_W-2:0], qbit};
	end

	// serial-parallel multiply, gain LSB first; halve after every bit but the top one
	always_comb begin
		sumy = accy_q + (k_q[0] ? ACCY_W'(y_q) : '0);
		sump = accp_q + (a_q[0] ? ACCP_W'(p_q) : '0);
	end

	always_comb begin
		xn_raw = XN_W'(signed'({1'b0, x_q})) + XN_W'(accy_q);
		if (xn_raw < 0) begin
			xn = '0;
		end else if (xn_raw > XN_W'(signed'({1'b0, VAL_MAX}))) begin
			xn = VAL_MAX;
		end else begin
			xn = xn_raw[VAL_W-1:0];
		end
		pn_raw = PN_W'(accp_q) + PN_W'(q_noise_q);
		pn     = (pn_raw > PN_W'(VAL_MAX)) ? VAL_MAX : pn_raw[VAL_W-1:0];
		near   = (CMP_W'(xn) <= (CMP_W'(thresh_q) << F));
		fin_go = (state_q == ST_FIN) && (!out_valid_q || dout.ready);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			q_noise_q <= Q_RST;
			r_noise_q <= R_RST;
			thresh_q  <= NEAR_THRESHOLD_RST;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_PROCESS_NOISE:     q_noise_q <= cfg.data[NOISE_W-1:0];
				REG_MEASUREMENT_NOISE: r_noise_q <= cfg.data[NOISE_W-1:0];
				REG_NEAR_THRESHOLD:    thresh_q  <= cfg.data[THRESH_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			x_q         <= '0;
			p_q         <= P_RST;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && dout.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (din.valid) begin
						state_q <= ST_DIV;
						cnt_q   <= '0;
					end
				end
				ST_DIV: begin
					if (cnt_q == CNT_LAST) begin
						state_q <= ST_MUL;
						cnt_q   <= '0;
					end else begin
						cnt_q <= cnt_q + CNT_W'(1);
					end
				end
				ST_MUL: begin
					if (cnt_q == CNT_LAST) begin
						state_q <= ST_FIN;
					end else begin
						cnt_q <= cnt_q + CNT_W'(1);
					end
				end
				ST_FIN: begin
					if (fin_go) begin
						state_q     <= ST_IDLE;
						x_q         <= xn;
						p_q         <= pn;
						out_valid_q <= 1'b1;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				rem_q <= R_W'(p_q);
				s_q   <= S_W'(p_q) + S_W'(r_noise_q);
				k_q   <= '0;
				y_q   <= signed'({1'b0, din.reading_cm, {F{1'b0}}}) - signed'({1'b0, x_q});
			end
			ST_DIV: begin
				rem_q <= rem_next;
				k_q   <= k_next;
				if (cnt_q == CNT_LAST) begin
					a_q    <= K_ONE - k_next;
					accy_q <= '0;
					accp_q <= '0;
				end
			end
			ST_MUL: begin
				if (cnt_q == CNT_LAST) begin
					accy_q <= sumy;
					accp_q <= sump;
				end else begin
					accy_q <= sumy >>> 1;
					accp_q <= sump >> 1;
					k_q    <= k_q >> 1;
					a_q    <= a_q >> 1;
				end
			end
			ST_FIN: begin
				if (fin_go) begin
					out_dist_q <= xn;
					out_near_q <= near;
				end
			end
			default: ;
		endcase
	end

endmodule
`default_nettype wire
